// File: src/hdp_pkg.sv
// Shared constants, codes and the arctangent step table of the Hammersley disk point generator.
package hdp_pkg;

	localparam int ANG_BITS = 30;
	localparam int CW = 34;

	localparam logic signed [CW-1:0] PI_QUARTER_Q30 = 34'sd843314857;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	localparam logic signed [CW-1:0] ATAN_TABLE [10] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
		34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149
	};

	typedef logic [1:0] oct_t;
	localparam oct_t OCT_RIGHT = 2'd0;
	localparam oct_t OCT_TOP = 2'd1;
	localparam oct_t OCT_LEFT = 2'd2;
	localparam oct_t OCT_BOTTOM = 2'd3;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_SAMPLE_COUNT = 2'd0;
	localparam cfg_idx_t CFG_DISK_MODE = 2'd1;

	// Arctangent of 2^-i in Q30; past the table the angle equals the shift itself.
	function automatic logic signed [CW-1:0] atan_step(input int unsigned i);
		logic [3:0] idx;
		idx = i[3:0];
		if (i < 10) begin
			return ATAN_TABLE[idx];
		end
		if (i <= 30) begin
			return 34'sd1 <<< (30 - i);
		end
		return '0;
	endfunction

endpackage

// File: src/hdp_divider.sv
// Pipelined restoring divider that produces one quotient bit per register stage.
module hdp_divider
	import hdp_pkg::*;
#(
	parameter int RW = 17,
	parameter int STEPS = 15,
	parameter int SW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [RW-1:0]    in_rem,
	input  logic [RW-1:0]    in_den,
	input  logic [SW-1:0]    in_side,
	output logic             out_valid,
	output logic [STEPS-1:0] out_quot,
	output logic [SW-1:0]    out_side
);

	logic             v_s    [STEPS+1];
	logic [RW-1:0]    rem_s  [STEPS];
	logic [RW-1:0]    den_s  [STEPS];
	logic [STEPS-1:0] quot_s [STEPS+1];
	logic [SW-1:0]    side_s [STEPS+1];

	assign v_s[0] = in_valid;
	assign rem_s[0] = in_rem;
	assign den_s[0] = in_den;
	assign quot_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic [RW:0] dbl;
		logic        ge;

		always_comb begin
			dbl = {rem_s[g], 1'b0};
			ge = dbl >= {1'b0, den_s[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			quot_s[g+1] <= {quot_s[g][STEPS-2:0], ge};
			side_s[g+1] <= side_s[g];
		end

		if (g < STEPS - 1) begin : g_carry
			logic [RW:0] diff;
			assign diff = dbl - {1'b0, den_s[g]};
			always_ff @(posedge clk) begin
				rem_s[g+1] <= ge ? diff[RW-1:0] : dbl[RW-1:0];
				den_s[g+1] <= den_s[g];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_quot = quot_s[STEPS];
	assign out_side = side_s[STEPS];

endmodule

// File: src/hdp_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q30, one micro-rotation per stage.
module hdp_cordic
	import hdp_pkg::*;
#(
	parameter int STEPS = 16,
	parameter int SW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] in_z,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic signed [CW-1:0] out_cos,
	output logic signed [CW-1:0] out_sin,
	output logic [SW-1:0]        out_side
);

	logic                 v_s    [STEPS+1];
	logic signed [CW-1:0] x_s    [STEPS+1];
	logic signed [CW-1:0] y_s    [STEPS+1];
	logic signed [CW-1:0] z_s    [STEPS];
	logic [SW-1:0]        side_s [STEPS+1];

	assign v_s[0] = in_valid;
	assign x_s[0] = CORDIC_GAIN_Q30;
	assign y_s[0] = '0;
	assign z_s[0] = in_z;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic                 up;

		always_comb begin
			dx = y_s[g] >>> g;
			dy = x_s[g] >>> g;
			up = !z_s[g][CW-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			x_s[g+1] <= up ? x_s[g] - dx : x_s[g] + dx;
			y_s[g+1] <= up ? y_s[g] + dy : y_s[g] - dy;
			side_s[g+1] <= side_s[g];
		end

		if (g < STEPS - 1) begin : g_angle
			always_ff @(posedge clk) begin
				z_s[g+1] <= up ? z_s[g] - atan_step(g) : z_s[g] + atan_step(g);
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_cos = x_s[STEPS];
	assign out_sin = y_s[STEPS];
	assign out_side = side_s[STEPS];

endmodule

// File: src/hammersley_disk_point.sv
// Top level of the Hammersley point generator with concentric disk mapping.
//
// A sample index is taken at every rising edge where start is high and busy is low; busy
// never rises, so the block takes one index in every cycle. Each index gives exactly one
// word on point_x, point_y and index_out_of_range, shown for a single cycle with done
// high, in the order the indices came in. The receiver cannot stall the block, so it must
// take each word in the cycle it appears. The path runs through stage 1, the divider for
// y = (k+0.5)/count, stages 2 and 3, the octant-ratio divider (both one bit per stage),
// stage 4, the CORDIC (one micro-rotation per stage), stages 5, 6, the output register. The x
// coordinate is the bit mirror of the index, y is (2k+1)/(2*sample_count); in disk mode both
// are stretched to [-1,1) and passed through the concentric square-to-disk mapping. Results
// are signed Q1.15 with the default FRAC_BITS; an index at or above sample_count gives zeros
// with index_out_of_range set. The configuration channel is always ready; sample_count and
// disk_mode must only be changed while no word is in flight.
module hammersley_disk_point
	import hdp_pkg::*;
#(
	parameter int INDEX_BITS = 16,
	parameter int FRAC_BITS = 15,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        sample_index,
	output logic               done,
	output logic signed [15:0] point_x,
	output logic signed [15:0] point_y,
	output logic               index_out_of_range,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  cfg_idx_t           cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int F = FRAC_BITS;
	localparam int IB = INDEX_BITS;
	localparam int YRW = 17;
	localparam int PW = F + 2 + CW;
	localparam logic signed [F+1:0] ONE = {2'b01, {F{1'b0}}};
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (ANG_BITS - 1);
	localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< F) - PW'(1);
	localparam logic signed [PW-1:0] SAT_LO = -(PW'(1) <<< F);

	typedef struct packed {
		logic         oor;
		logic [F-1:0] x;
	} yside_t;

	typedef struct packed {
		logic         ib;
		logic         neg;
		oct_t         oct;
		logic [F:0]   r;
		logic         oor;
		logic [F-1:0] x;
		logic [F-1:0] y;
	} rside_t;

	typedef struct packed {
		oct_t         oct;
		logic [F:0]   r;
		logic         oor;
		logic [F-1:0] x;
		logic [F-1:0] y;
	} cside_t;

	// Configuration registers. Writes are always taken.
	logic [15:0] count_q;
	logic        disk_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd16;
			disk_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLE_COUNT: count_q <= cfg_data;
				CFG_DISK_MODE: disk_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1: radical inverse by mirroring the low index bits, and the range test.
	logic [IB+15:0] kext;
	logic [IB-1:0]  rev;
	logic [IB+F-1:0] rev_wide;

	always_comb begin
		kext = {{IB{1'b0}}, sample_index};
		for (int i = 0; i < IB; i++) begin
			rev[IB-1-i] = kext[i];
		end
		rev_wide = {rev, {F{1'b0}}};
	end

	logic           v_s1;
	logic [F-1:0]   x_s1;
	logic [YRW-1:0] rem_s1;
	logic [YRW-1:0] den_s1;
	logic           oor_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= rev_wide[IB+F-1:IB];
		rem_s1 <= {sample_index, 1'b1};
		den_s1 <= {count_q, 1'b0};
		oor_s1 <= sample_index >= count_q;
	end

	// The y coordinate: one quotient bit per stage.
	yside_t       yside_in;
	yside_t       yside_out;
	logic         yv;
	logic [F-1:0] yq;

	assign yside_in = '{oor: oor_s1, x: x_s1};

	hdp_divider #(
		.RW(YRW),
		.STEPS(F),
		.SW($bits(yside_t))
	) u_ydiv (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s1),
		.in_rem(rem_s1),
		.in_den(den_s1),
		.in_side(yside_in),
		.out_valid(yv),
		.out_quot(yq),
		.out_side(yside_out)
	);

	// Stage 2: stretch to [-1,1) and pick the octant case. The origin lands in the bottom
	// case with a radius of zero, which forces a zero result.
	logic signed [F+1:0] sx;
	logic signed [F+1:0] sy;
	oct_t                oct_c;
	logic signed [F+1:0] num_c;
	logic signed [F+1:0] den_c;
	logic signed [F+1:0] r_c;
	logic                negf_c;

	always_comb begin
		sx = $signed({1'b0, yside_out.x, 1'b0}) - ONE;
		sy = $signed({1'b0, yq, 1'b0}) - ONE;
		if (sx > -sy) begin
			if (sx > sy) begin
				oct_c = OCT_RIGHT;
				num_c = sy;
				den_c = sx;
				r_c = sx;
				negf_c = 1'b0;
			end else begin
				oct_c = OCT_TOP;
				num_c = sx;
				den_c = sy;
				r_c = sy;
				negf_c = 1'b1;
			end
		end else if (sx < sy) begin
			oct_c = OCT_LEFT;
			num_c = sy;
			den_c = sx;
			r_c = -sx;
			negf_c = 1'b0;
		end else begin
			oct_c = OCT_BOTTOM;
			num_c = sx;
			den_c = sy;
			r_c = -sy;
			negf_c = 1'b1;
		end
	end

	logic                v_s2;
	oct_t                oct_s2;
	logic signed [F+1:0] num_s2;
	logic signed [F+1:0] den_s2;
	logic [F:0]          r_s2;
	logic                negf_s2;
	logic                oor_s2;
	logic [F-1:0]        x_s2;
	logic [F-1:0]        y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= yv;
		end
	end

	always_ff @(posedge clk) begin
		oct_s2 <= oct_c;
		num_s2 <= num_c;
		den_s2 <= den_c;
		r_s2 <= r_c[F:0];
		negf_s2 <= negf_c;
		oor_s2 <= yside_out.oor;
		x_s2 <= yside_out.x;
		y_s2 <= yq;
	end

	// Stage 3: magnitudes and the integer bit of the ratio, which reaches one only when
	// the two coordinates have equal magnitude.
	logic [F+1:0] un_full;
	logic [F+1:0] ud_full;
	logic [F:0]   un;
	logic [F:0]   ud;
	logic         ib_c;

	always_comb begin
		un_full = num_s2[F+1] ? -num_s2 : num_s2;
		ud_full = den_s2[F+1] ? -den_s2 : den_s2;
		un = un_full[F:0];
		ud = ud_full[F:0];
		ib_c = un >= ud;
	end

	logic   v_s3;
	logic [F:0] rem_s3;
	logic [F:0] den_s3;
	rside_t rside_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rem_s3 <= ib_c ? un - ud : un;
		den_s3 <= ud;
		rside_s3 <= '{
			ib: ib_c,
			neg: (num_s2[F+1] != den_s2[F+1]) ^ negf_s2,
			oct: oct_s2,
			r: r_s2,
			oor: oor_s2,
			x: x_s2,
			y: y_s2
		};
	end

	// Fraction bits of the octant ratio.
	rside_t       rside_out;
	logic         rv;
	logic [F-1:0] rq;

	hdp_divider #(
		.RW(F + 1),
		.STEPS(F),
		.SW($bits(rside_t))
	) u_rdiv (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s3),
		.in_rem(rem_s3),
		.in_den(den_s3),
		.in_side(rside_s3),
		.out_valid(rv),
		.out_quot(rq),
		.out_side(rside_out)
	);

	// Stage 4: signed ratio times pi/4 gives the CORDIC angle in Q30.
	logic [F:0]          qmag;
	logic signed [F+1:0] qsig;

	always_comb begin
		qmag = {rside_out.ib, rq};
		qsig = rside_out.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
	end

	logic                    v_s4;
	logic signed [F+CW+1:0]  prod_s4;
	cside_t                  cside_s4;
	logic signed [F+CW+1:0]  zwide;
	logic signed [CW-1:0]    z_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= rv;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= qsig * PI_QUARTER_Q30;
		cside_s4 <= '{
			oct: rside_out.oct,
			r: rside_out.r,
			oor: rside_out.oor,
			x: rside_out.x,
			y: rside_out.y
		};
	end

	assign zwide = prod_s4 >>> F;
	assign z_c = zwide[CW-1:0];

	cside_t               cside_out;
	logic                 cv;
	logic signed [CW-1:0] ccos;
	logic signed [CW-1:0] csin;

	hdp_cordic #(
		.STEPS(CORDIC_STEPS),
		.SW($bits(cside_t))
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s4),
		.in_z(z_c),
		.in_side(cside_s4),
		.out_valid(cv),
		.out_cos(ccos),
		.out_sin(csin),
		.out_side(cside_out)
	);

	// Stage 5: turn the reduced-angle result back into its octant.
	logic                 v_s5;
	logic signed [CW-1:0] tx_s5;
	logic signed [CW-1:0] ty_s5;
	cside_t               cside_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= cv;
		end
	end

	always_ff @(posedge clk) begin
		cside_s5 <= cside_out;
		case (cside_out.oct)
			OCT_RIGHT: begin
				tx_s5 <= ccos;
				ty_s5 <= csin;
			end
			OCT_TOP: begin
				tx_s5 <= -csin;
				ty_s5 <= ccos;
			end
			OCT_LEFT: begin
				tx_s5 <= -ccos;
				ty_s5 <= -csin;
			end
			default: begin
				tx_s5 <= csin;
				ty_s5 <= -ccos;
			end
		endcase
	end

	// Stage 6: scale by the radius.
	logic                 v_s6;
	logic signed [PW-1:0] px_s6;
	logic signed [PW-1:0] py_s6;
	cside_t               cside_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		px_s6 <= $signed({1'b0, cside_s5.r}) * tx_s5;
		py_s6 <= $signed({1'b0, cside_s5.r}) * ty_s5;
		cside_s6 <= cside_s5;
	end

	// Stage 7: round half up to the output format, saturate, and pick the mode, or zeros for an index out of range.
	logic signed [PW-1:0] rx;
	logic signed [PW-1:0] ry;
	logic signed [PW-1:0] satx;
	logic signed [PW-1:0] saty;
	logic signed [PW-1:0] selx;
	logic signed [PW-1:0] sely;

	always_comb begin
		rx = (px_s6 + ROUND_HALF) >>> ANG_BITS;
		ry = (py_s6 + ROUND_HALF) >>> ANG_BITS;
		satx = (rx > SAT_HI) ? SAT_HI : ((rx < SAT_LO) ? SAT_LO : rx);
		saty = (ry > SAT_HI) ? SAT_HI : ((ry < SAT_LO) ? SAT_LO : ry);
		if (cside_s6.oor) begin
			selx = '0;
			sely = '0;
		end else if (disk_q) begin
			selx = satx;
			sely = saty;
		end else begin
			selx = PW'(cside_s6.x);
			sely = PW'(cside_s6.y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		point_x <= selx[15:0];
		point_y <= sely[15:0];
		index_out_of_range <= cside_s6.oor;
	end

endmodule

// File: src/hdp_checker.sv
// Port-level checks of the Hammersley disk point generator, bound to its top level.
module hdp_checker
	import hdp_pkg::*;
#(
	parameter int LATENCY = 53
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [15:0]        sample_index,
	input logic               done,
	input logic signed [15:0] point_x,
	input logic signed [15:0] point_y,
	input logic               index_out_of_range,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input cfg_idx_t           cfg_index,
	input logic [15:0]        cfg_data
);

	localparam int CNTW = $clog2(LATENCY + 1);

	logic [CNTW-1:0] warm_q;
	logic [15:0]     count_q;
	logic            warm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
			count_q <= 16'd16;
		end else begin
			if (warm_q != CNTW'(LATENCY)) begin
				warm_q <= warm_q + 1'b1;
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_SAMPLE_COUNT) begin
				count_q <= cfg_data;
			end
		end
	end

	assign warm = warm_q == CNTW'(LATENCY);

	// Every accepted word comes out after the fixed latency, and nothing else does.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> done == $past(start && !busy, LATENCY))
		else $error("done does not follow an accepted word by the fixed latency");

	// The range flag matches the index and count seen at acceptance.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done |-> index_out_of_range == $past(sample_index >= count_q, LATENCY))
		else $error("index_out_of_range disagrees with the accepted index");

	// An index out of range gives the zero point.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && index_out_of_range |-> point_x == 16'sd0 && point_y == 16'sd0)
		else $error("out-of-range word carries a nonzero point");

endmodule

bind hammersley_disk_point hdp_checker #(
	.LATENCY(2 * FRAC_BITS + CORDIC_STEPS + 7)
) u_hdp_checker (.*);

// File: tb/sv/tb.sv
// Self-checking bench for the Hammersley disk point generator against a built-in predictor.
module tb;
	import hdp_pkg::*;

	localparam int IDX_W = 16;
	localparam int FRAC = 15;
	localparam int STEPS = 16;
	// The latency that the checker binds, used to time the driver and the end of the test.
	localparam int LATENCY = 2 * FRAC + STEPS + 7;

	typedef struct packed {
		logic [15:0] sample;
	} index_word_t;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic               oor;
	} point_word_t;

	typedef struct packed {
		logic        is_cfg;
		cfg_idx_t    reg_sel;
		logic [15:0] data;
	} job_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [15:0]        sample_index;
	logic               done;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic               index_out_of_range;
	logic               cfg_valid;
	logic               cfg_ready;
	cfg_idx_t           cfg_index;
	logic [15:0]        cfg_data;

	hammersley_disk_point u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample_index(sample_index),
		.done(done),
		.point_x(point_x),
		.point_y(point_y),
		.index_out_of_range(index_out_of_range),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// The predictor keeps its own copy of the two registers.
	logic [15:0] pred_count;
	logic        pred_disk;

	job_t        job_queue[$];
	point_word_t expected_points[$];
	int          mismatches;
	int          idle_pct;
	logic        stim_done;
	int unsigned quiet_cycles;

	// Floor division by a power of two on signed 64-bit values.
	function automatic longint floor_shr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint atan_q30(input int i);
		longint tbl[10];
		tbl = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10) begin
			return tbl[i];
		end
		if (i <= 30) begin
			return longint'(1) << (30 - i);
		end
		return 0;
	endfunction

	// Ratio num/den with FRAC fraction bits, truncated toward zero.
	function automatic longint octant_ratio(input longint num, input longint den);
		longint un;
		longint ud;
		longint q;
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		if (ud == 0) begin
			return 0;
		end
		q = (un << FRAC) / ud;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	// Rotation-mode CORDIC: cosine and sine of q*pi/4 in Q30.
	task automatic rotate_angle(input longint q, output longint c, output longint s);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		x = 652032874;
		y = 0;
		z = floor_shr(q * 64'sd843314857, FRAC);
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_q30(i);
			end else begin
				x += dx;
				y -= dy;
				z += atan_q30(i);
			end
		end
		c = x;
		s = y;
	endtask

	// Radius times a Q30 trig value, rounded half up and clamped to Q1.15.
	function automatic longint scale_clamp(input longint r, input longint t);
		longint v;
		v = floor_shr(r * t + (longint'(1) << (ANG_BITS - 1)), ANG_BITS);
		if (v > (longint'(1) << FRAC) - 1) begin
			v = (longint'(1) << FRAC) - 1;
		end
		if (v < -(longint'(1) << FRAC)) begin
			v = -(longint'(1) << FRAC);
		end
		return v;
	endfunction

	task automatic predict_point(input logic [15:0] k, output point_word_t res);
		longint rev;
		longint x;
		longint y;
		longint sx;
		longint sy;
		longint r;
		longint c;
		longint s;
		longint tx;
		longint ty;
		longint one;
		res = '0;
		if (k >= pred_count) begin
			res.oor = 1'b1;
			return;
		end
		rev = 0;
		for (int i = 0; i < IDX_W; i++) begin
			rev |= longint'(k[i]) << (IDX_W - 1 - i);
		end
		x = (rev << FRAC) >> IDX_W;
		y = ((2 * longint'(k) + 1) << FRAC) / (2 * longint'(pred_count));
		if (!pred_disk) begin
			res.px = x[15:0];
			res.py = y[15:0];
			return;
		end
		one = longint'(1) << FRAC;
		sx = 2 * x - one;
		sy = 2 * y - one;
		// The four octant cases, with the origin giving zero radius.
		if (sx > -sy) begin
			if (sx > sy) begin
				r = sx;
				rotate_angle(octant_ratio(sy, sx), c, s);
				tx = c;
				ty = s;
			end else begin
				r = sy;
				rotate_angle(-octant_ratio(sx, sy), c, s);
				tx = -s;
				ty = c;
			end
		end else if (sx < sy) begin
			r = -sx;
			rotate_angle(octant_ratio(sy, sx), c, s);
			tx = -c;
			ty = -s;
		end else if (sy != 0) begin
			r = -sy;
			rotate_angle(-octant_ratio(sx, sy), c, s);
			tx = s;
			ty = -c;
		end else begin
			r = 0;
			tx = 0;
			ty = 0;
		end
		x = scale_clamp(r, tx);
		y = scale_clamp(r, ty);
		res.px = x[15:0];
		res.py = y[15:0];
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// The driver: a register write waits until every word has come back and the
	// pipeline has been quiet for its full depth, so no index is in flight.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			sample_index <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= CFG_SAMPLE_COUNT;
			cfg_data <= '0;
		end else begin
			point_word_t res;
			index_word_t w;
			if (start && !busy) begin
				w.sample = sample_index;
				predict_point(w.sample, res);
				expected_points.insert(expected_points.size(), res);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SAMPLE_COUNT) begin
					pred_count = cfg_data;
				end else begin
					pred_disk = cfg_data[0];
				end
			end
			if ((start && busy) || (cfg_valid && !cfg_ready)) begin
				// Hold the current word until it is taken.
			end else if (job_queue.size() == 0 || $urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				cfg_valid <= 1'b0;
			end else if (job_queue[0].is_cfg) begin
				start <= 1'b0;
				if (expected_points.size() == 0 && !(start && !busy)
						&& quiet_cycles > LATENCY + 2 && !cfg_valid) begin
					cfg_valid <= 1'b1;
					cfg_index <= job_queue[0].reg_sel;
					cfg_data <= job_queue[0].data;
					void'(job_queue.pop_front());
				end else begin
					cfg_valid <= 1'b0;
				end
			end else begin
				cfg_valid <= 1'b0;
				start <= 1'b1;
				sample_index <= job_queue[0].data;
				void'(job_queue.pop_front());
			end
		end
	end

	// Counts cycles since the last accepted index, used to gate register writes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if (start && !busy) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < 1000) begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// The monitor compares each word against the oldest expected point.
	always @(posedge clk) begin
		if (arst_n && done) begin
			point_word_t exp_w;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected word: x=%0d y=%0d oor=%0b",
						point_x, point_y, index_out_of_range);
				end
			end else begin
				exp_w = expected_points.pop_front();
				if (point_x !== exp_w.px || point_y !== exp_w.py
						|| index_out_of_range !== exp_w.oor) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected x=%0d y=%0d oor=%0b,",
							exp_w.px, exp_w.py, exp_w.oor,
							" got x=%0d y=%0d oor=%0b",
							point_x, point_y, index_out_of_range);
					end
				end
			end
		end
	end

	task automatic add_cfg(input cfg_idx_t sel, input logic [15:0] val);
		job_t j;
		j.is_cfg = 1'b1;
		j.reg_sel = sel;
		j.data = val;
		job_queue.insert(job_queue.size(), j);
	endtask

	task automatic add_index(input logic [15:0] k);
		job_t j;
		j.is_cfg = 1'b0;
		j.reg_sel = CFG_SAMPLE_COUNT;
		j.data = k;
		job_queue.insert(job_queue.size(), j);
	endtask

	// Mostly in-range indices, with a share past the count to hit the range flag.
	task automatic add_random_indices(input int n, input logic [15:0] cnt);
		for (int i = 0; i < n; i++) begin
			if (cnt != 0 && $urandom_range(99) < 85) begin
				add_index(16'($urandom_range(cnt - 1)));
			end else begin
				add_index(16'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		while (job_queue.size() != 0 || expected_points.size() != 0 || start) begin
			@(posedge clk);
		end
	endtask

	initial begin
		logic [15:0] cnt;
		mismatches = 0;
		idle_pct = 38;
		stim_done = 1'b0;
		pred_count = 16;
		pred_disk = 1'b1;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset setting: corners and out of range.
		add_index(16'd0);
		add_index(16'd8);
		add_index(16'd15);
		add_index(16'd16);
		add_index(16'hFFFF);
		add_index(16'd4);
		add_index(16'd12);
		// Full count: the low fifteen index bits reach the radical inverse, disk edges saturate.
		add_cfg(CFG_SAMPLE_COUNT, 16'hFFFF);
		add_index(16'h0000);
		add_index(16'h7FFF);
		add_index(16'h8000);
		add_index(16'hFFFE);
		add_index(16'hFFFF);
		add_index(16'h5555);
		add_index(16'hAAAA);
		// Square mode at the full count.
		add_cfg(CFG_DISK_MODE, 16'd0);
		add_index(16'h0000);
		add_index(16'hFFFE);
		add_index(16'h1234);
		// A count of zero puts every index out of range; a count of one leaves only zero.
		add_cfg(CFG_SAMPLE_COUNT, 16'd0);
		add_index(16'd0);
		add_index(16'd1);
		add_cfg(CFG_SAMPLE_COUNT, 16'd1);
		add_cfg(CFG_DISK_MODE, 16'd1);
		add_index(16'd0);
		add_index(16'd1);
		wait_drained();

		// Random phases across settings, changing the idling mix as we go.
		for (int ph = 0; ph < 9; ph++) begin
			idle_pct = (ph < 3) ? 38 : (ph < 6) ? 45 : 0;
			case (ph % 3)
				0: cnt = 16'($urandom_range(2, 64));
				1: cnt = 16'($urandom_range(1, 65535));
				default: cnt = 16'hFFFF;
			endcase
			add_cfg(CFG_SAMPLE_COUNT, cnt);
			add_cfg(CFG_DISK_MODE, 16'($urandom_range(1)));
			add_random_indices(100, cnt);
			wait_drained();
		end

		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && expected_points.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end

endmodule

// File: files.f
src/hdp_pkg.sv
src/hdp_divider.sv
src/hdp_cordic.sv
src/hammersley_disk_point.sv
src/hdp_checker.sv
tb/sv/tb.sv
